FILE: sv/configurable_lru_cache_controller_assert.svh
// Assertion macros shared by the cache controller.
// Each checks on the rising edge of clk and is off while rst_n is low.
`ifndef CONFIGURABLE_LRU_CACHE_CONTROLLER_ASSERT_SVH
`define CONFIGURABLE_LRU_CACHE_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define CLCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/clcc_pkg.sv
package clcc_pkg;

  localparam int NUM_LINES    = 16;
  localparam int LINE_W       = $clog2(NUM_LINES);
  localparam int ADDR_W       = 11;
  localparam int TAG_W        = 11;
  localparam int AGE_W        = 4;
  localparam int DATA_W       = 32;
  localparam int CNT_W        = 32;
  localparam int PLACE_W      = 2;
  localparam int MEMORY_WORDS = 2048;
  localparam int MEM_AW       = $clog2(MEMORY_WORDS);

  localparam logic [AGE_W-1:0] AGE_TOP      = AGE_W'(15);
  localparam logic [1:0]       MISS_PENALTY = 2'd3;

  // Placement codes
  localparam logic [PLACE_W-1:0] PL_DIRECT = 2'd0;
  localparam logic [PLACE_W-1:0] PL_FULL   = 2'd1;
  localparam logic [PLACE_W-1:0] PL_SET    = 2'd2;

  // Access kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] write_data;
  } clcc_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic                     hit;
    logic [1:0]               penalty_cycles;
    logic [CNT_W-1:0]         miss_total;
  } clcc_rsp_t;

  typedef logic [NUM_LINES-1:0][TAG_W-1:0] tag_vec_t;
  typedef logic [NUM_LINES-1:0][AGE_W-1:0] age_vec_t;

  // Lookup outcome handed from the tag compare to the control
  typedef struct packed {
    logic              hit;
    logic [LINE_W-1:0] hit_line;
    logic              fill;
    logic [LINE_W-1:0] victim;
    logic [TAG_W-1:0]  tag;
  } lkp_t;

endpackage

FILE: sv/configurable_lru_cache_controller.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_ready    clcc_req_t (mode, address, write_data)
// out_     output     out_valid / out_ready  clcc_rsp_t (read_data, hit, penalty, misses)
// cfg_     input      cfg_we                 cfg_wdata (placement)
//
// An item is taken with the lookup and the memory reads at acceptance, then finished
// in the busy state with the update of line state, memories and the result register.
// The backing and line memories give registered reads. After reset a clearing pass
// zeroes every word of the backing memory; no item is taken meanwhile. A waiting
// result holds the finishing cycle until taken.
`include "configurable_lru_cache_controller_assert.svh"

module configurable_lru_cache_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  clcc_pkg::clcc_req_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output clcc_pkg::clcc_rsp_t             out_data,
  input  logic                            cfg_we,
  input  logic [clcc_pkg::PLACE_W-1:0]    cfg_wdata
);
  import clcc_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [PLACE_W-1:0]   placement_r;
  logic [NUM_LINES-1:0] valid_r;
  tag_vec_t             tag_r;
  age_vec_t             age_r, age_nxt;
  logic [CNT_W-1:0]     miss_cnt_r, miss_cnt_nxt;
  clcc_req_t            req_r;
  lkp_t                 lkp, lkp_r;
  logic                 out_valid_r;
  clcc_rsp_t            out_data_r;

  logic                 accept;
  logic                 finish;
  logic                 clear_done;
  logic                 is_load;
  logic                 touch_en;
  logic                 fill_en;
  logic [LINE_W-1:0]    touch_idx;
  logic [AGE_W-1:0]     touch_age;
  logic                 line_we;
  logic [LINE_W-1:0]    line_waddr;
  logic [DATA_W-1:0]    line_wdata;
  logic [DATA_W-1:0]    line_rd;
  logic [DATA_W-1:0]    back_rd;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == ST_BUSY) && (!out_valid_r || out_ready);

  // Tag compare and victim choice on the incoming item
  clcc_lookup u_lookup (
    .placement (placement_r),
    .address   (in_data.address),
    .valid_vec (valid_r),
    .tag_vec   (tag_r),
    .age_vec   (age_r),
    .lkp       (lkp)
  );

  // Decode the held item
  assign is_load   = (req_r.mode == MODE_LOAD);
  assign fill_en   = is_load && !lkp_r.hit && lkp_r.fill;
  assign touch_en  = is_load && (lkp_r.hit || lkp_r.fill);
  assign touch_idx = lkp_r.hit ? lkp_r.hit_line : lkp_r.victim;
  assign touch_age = age_r[touch_idx];

  assign line_we    = finish && (((req_r.mode == MODE_STORE) && lkp_r.hit) || fill_en);
  assign line_waddr = lkp_r.hit ? lkp_r.hit_line : lkp_r.victim;
  assign line_wdata = (req_r.mode == MODE_STORE) ? DATA_W'(req_r.write_data) : back_rd;

  clcc_line_ram u_line_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (lkp.hit_line),
    .rd_data (line_rd),
    .wr_en   (line_we),
    .wr_addr (line_waddr),
    .wr_data (line_wdata)
  );

  clcc_backing_mem u_backing_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (accept),
    .rd_addr    (MEM_AW'(in_data.address)),
    .rd_data    (back_rd),
    .wr_en      (finish && (req_r.mode == MODE_STORE)),
    .wr_addr    (MEM_AW'(req_r.address)),
    .wr_data    (DATA_W'(req_r.write_data)),
    .clear_done (clear_done)
  );

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Age the other lines above the touched one, lift the touched line to the top
  always_comb begin
    age_nxt = age_r;
    if (finish && touch_en) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        if (LINE_W'(i) == touch_idx) begin
          age_nxt[i] = AGE_TOP;
        end else if (age_r[i] > touch_age) begin
          age_nxt[i] = age_r[i] - AGE_W'(1);
        end
      end
    end
  end

  // Count load misses, hold at the top
  always_comb begin
    miss_cnt_nxt = miss_cnt_r;
    if (is_load && !lkp_r.hit && (miss_cnt_r != '1)) begin
      miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
    end
  end

  // Control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      placement_r <= PL_DIRECT;
      valid_r     <= '0;
      tag_r       <= '0;
      age_r       <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        placement_r <= cfg_wdata;
      end
      age_r <= age_nxt;
      if (finish) begin
        miss_cnt_r <= miss_cnt_nxt;
      end
      if (finish && fill_en) begin
        valid_r[lkp_r.victim] <= 1'b1;
        tag_r[lkp_r.victim]   <= lkp_r.tag;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the item and its lookup; load the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
      lkp_r <= lkp;
    end
    if (finish) begin
      out_data_r.read_data      <= !is_load ? '0 : (lkp_r.hit ? line_rd : back_rd);
      out_data_r.hit            <= lkp_r.hit;
      out_data_r.penalty_cycles <= (is_load && !lkp_r.hit) ? MISS_PENALTY : 2'd0;
      out_data_r.miss_total     <= miss_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CLCC_ASSERT_NOW(a_no_accept_in_clear, !clear_done, !in_ready, "item taken during clear")
  `CLCC_ASSERT_NEXT(a_touch_tops_age, finish && touch_en, age_r[$past(touch_idx)] == AGE_TOP, "touched line not at top age")
  `CLCC_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(state_r) == ST_BUSY, "result without work")
  `CLCC_ASSERT_NOW(a_miss_step, miss_cnt_r != $past(miss_cnt_r), miss_cnt_r == $past(miss_cnt_r) + CNT_W'(1), "miss count jumped")

endmodule

FILE: sv/clcc_lookup.sv
module clcc_lookup (
  input  logic [clcc_pkg::PLACE_W-1:0] placement,
  input  logic [clcc_pkg::ADDR_W-1:0]  address,
  input  logic [clcc_pkg::NUM_LINES-1:0] valid_vec,
  input  clcc_pkg::tag_vec_t           tag_vec,
  input  clcc_pkg::age_vec_t           age_vec,
  output clcc_pkg::lkp_t               lkp
);
  import clcc_pkg::*;

  logic [NUM_LINES-1:0] cand;
  logic [TAG_W-1:0]     cmp_tag;
  logic                 cached;
  logic [LINE_W-1:0]    base;
  logic [LINE_W-1:0]    way_idx;
  logic [LINE_W-1:0]    victim;
  logic                 found;
  logic                 hit_any;
  logic [LINE_W-1:0]    hit_idx;
  logic                 fill;

  // Select candidate lines and the tag to compare
  always_comb begin
    cand    = '0;
    cmp_tag = '0;
    cached  = 1'b1;
    base    = {address[1:0], 2'b00};
    case (placement)
      PL_DIRECT: begin
        cand[address[LINE_W-1:0]] = 1'b1;
        cmp_tag = TAG_W'(address >> 4);
      end
      PL_FULL: begin
        cand    = '1;
        cmp_tag = TAG_W'(address);
      end
      PL_SET: begin
        for (int i = 0; i < NUM_LINES; i++) begin
          cand[i] = (LINE_W'(i) >> 2) == LINE_W'(address[1:0]);
        end
        cmp_tag = TAG_W'(address >> 2);
      end
      default: begin
        cached = 1'b0;
      end
    endcase
  end

  // Find the lowest matching valid line
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (cand[i] && valid_vec[i] && tag_vec[i] == cmp_tag) begin
        hit_any = 1'b1;
        hit_idx = LINE_W'(i);
      end
    end
  end

  // Pick the victim line for a load miss
  always_comb begin
    victim  = base;
    found   = 1'b1;
    way_idx = base;
    case (placement)
      PL_DIRECT: begin
        victim = address[LINE_W-1:0];
      end
      PL_FULL: begin
        found = 1'b0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
          if (age_vec[i] == '0) begin
            victim = LINE_W'(i);
            found  = 1'b1;
          end
        end
      end
      PL_SET: begin
        for (int k = 1; k < 4; k++) begin
          way_idx = base + LINE_W'(k);
          if (age_vec[way_idx] < age_vec[victim]) begin
            victim = way_idx;
          end
        end
      end
      default: begin
        found = 1'b0;
      end
    endcase
    fill = cached && found;
  end

  // Pack the lookup outcome
  assign lkp = '{hit: hit_any, hit_line: hit_idx, fill: fill, victim: victim, tag: cmp_tag};

endmodule

FILE: sv/clcc_line_ram.sv
module clcc_line_ram (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [clcc_pkg::LINE_W-1:0]   rd_addr,
  output logic [clcc_pkg::DATA_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [clcc_pkg::LINE_W-1:0]   wr_addr,
  input  logic [clcc_pkg::DATA_W-1:0]   wr_data
);
  import clcc_pkg::*;

  logic [DATA_W-1:0] mem [NUM_LINES];
  logic [DATA_W-1:0] rd_data_r;

  // Write one line
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one line, hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/clcc_backing_mem.sv
module clcc_backing_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [clcc_pkg::MEM_AW-1:0]   rd_addr,
  output logic [clcc_pkg::DATA_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [clcc_pkg::MEM_AW-1:0]   wr_addr,
  input  logic [clcc_pkg::DATA_W-1:0]   wr_data,
  output logic                          clear_done
);
  import clcc_pkg::*;

  logic [DATA_W-1:0] mem [MEMORY_WORDS];
  logic [DATA_W-1:0] rd_data_r;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic              clr_busy_r;
  logic              we;
  logic [MEM_AW-1:0] waddr;
  logic [DATA_W-1:0] wdata;

  // Sweep zeros through every word after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      if (clr_cnt_r == MEM_AW'(MEMORY_WORDS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  assign we    = clr_busy_r || wr_en;
  assign waddr = clr_busy_r ? clr_cnt_r : wr_addr;
  assign wdata = clr_busy_r ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one word, hold until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_done = !clr_busy_r;

endmodule

FILE: dv/configurable_lru_cache_controller_test.sv
`timescale 1ns / 100ps

module configurable_lru_cache_controller_test;
  import clcc_pkg::*;

  // Placement code 3 has no name in the package: the cache is bypassed
  localparam logic [PLACE_W-1:0] PL_BYPASS = 2'd3;
  localparam int MAX_WAIT     = 18;
  localparam int RESET_CYCLES = 6;
  // Covers the clearing pass after reset plus the longest gap and stall, with margin
  localparam int IDLE_LIMIT   = 4 * MEMORY_WORDS + 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_SIZE    = 24;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  clcc_req_t            in_data;
  logic                 out_valid;
  logic                 out_ready;
  clcc_rsp_t            out_data;
  logic                 cfg_we;
  logic [PLACE_W-1:0]   cfg_wdata;

  // Mirror of the cache and backing memory
  logic [PLACE_W-1:0]   placement_mirror;
  logic                 cl_valid [NUM_LINES];
  logic [TAG_W-1:0]     cl_tag [NUM_LINES];
  logic [DATA_W-1:0]    cl_word [NUM_LINES];
  logic [AGE_W-1:0]     cl_rank [NUM_LINES];
  logic [DATA_W-1:0]    mem_image [MEMORY_WORDS];
  logic [CNT_W-1:0]     load_misses;

  clcc_rsp_t            pending_rsp_q [$];
  int                   mismatches;
  int                   load_count;
  int                   store_count;
  int                   hit_count;
  int                   idle_cycles;
  bit                   send_calm;
  bit                   recv_calm;

  configurable_lru_cache_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Wait cycles before an item; zero throughout a calm stretch
  function automatic int draw_wait(input bit calm);
    if (calm || $urandom_range(0, 4) == 0) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Make a line most recent; lines ranked above its old age drop one
  function automatic void promote_line(input int idx);
    logic [AGE_W-1:0] old_rank;
    old_rank = cl_rank[idx];
    for (int i = 0; i < NUM_LINES; i++) begin
      if (i != idx && cl_rank[i] > old_rank) cl_rank[i] = cl_rank[i] - 1'b1;
    end
    cl_rank[idx] = AGE_TOP;
  endfunction

  // Expected response of one access; updates the mirror
  function automatic clcc_rsp_t predict_access(input clcc_req_t req);
    clcc_rsp_t        rsp;
    int               first;
    int               span;
    int               hit_line;
    int               victim;
    bit               cached;
    bit               found;
    logic [TAG_W-1:0] tag;
    rsp = '0;
    cached = 1'b1;
    first = 0;
    span = 0;
    tag = '0;
    case (placement_mirror)
      PL_DIRECT: begin
        first = int'(req.address[3:0]);
        span  = 1;
        tag   = TAG_W'(req.address >> 4);
      end
      PL_FULL: begin
        span = NUM_LINES;
        tag  = TAG_W'(req.address);
      end
      PL_SET: begin
        first = int'(req.address[1:0]) * 4;
        span  = 4;
        tag   = TAG_W'(req.address >> 2);
      end
      default: begin
        cached = 1'b0;
      end
    endcase

    // Look up the candidate lines, lowest first
    hit_line = -1;
    for (int i = first; i < first + span; i++) begin
      if (hit_line < 0 && cl_valid[i] && cl_tag[i] == tag) hit_line = i;
    end
    rsp.hit = (hit_line >= 0);

    if (req.mode == MODE_STORE) begin
      // Write through; no allocation, ages untouched
      if (hit_line >= 0) cl_word[hit_line] = req.write_data;
      mem_image[req.address] = req.write_data;
    end else if (hit_line >= 0) begin
      rsp.read_data = cl_word[hit_line];
      promote_line(hit_line);
    end else begin
      if (load_misses != '1) load_misses = load_misses + 1'b1;
      rsp.penalty_cycles = MISS_PENALTY;
      rsp.read_data = mem_image[req.address];
      if (cached) begin
        victim = first;
        found = 1'b0;
        if (placement_mirror == PL_FULL) begin
          for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (cl_rank[i] == '0) begin
              victim = i;
              found = 1'b1;
            end
          end
        end else begin
          found = 1'b1;
          for (int i = first + 1; i < first + span; i++) begin
            if (cl_rank[i] < cl_rank[victim]) victim = i;
          end
        end
        if (found) begin
          promote_line(victim);
          cl_valid[victim] = 1'b1;
          cl_tag[victim] = tag;
          cl_word[victim] = rsp.read_data;
        end
      end
    end
    rsp.miss_total = load_misses;
    return rsp;
  endfunction

  // Check each result against the oldest prediction, then predict new items
  always @(posedge clk) begin
    clcc_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("result with no access outstanding");
          mismatches++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected 0x%08h, got 0x%08h", want.read_data,
                   out_data.read_data);
            mismatches++;
          end
          if (out_data.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_data.hit);
            mismatches++;
          end
          if (out_data.penalty_cycles !== want.penalty_cycles) begin
            $error("penalty_cycles: expected %0d, got %0d", want.penalty_cycles,
                   out_data.penalty_cycles);
            mismatches++;
          end
          if (out_data.miss_total !== want.miss_total) begin
            $error("miss_total: expected %0d, got %0d", want.miss_total,
                   out_data.miss_total);
            mismatches++;
          end
          if (want.hit) hit_count++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_STORE) store_count++;
        else load_count++;
        pending_rsp_q.insert(pending_rsp_q.size(), predict_access(in_data));
      end
      if (cfg_we) placement_mirror = cfg_wdata;
    end
  end

  // Abort when no item moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL configurable_lru_cache_controller");
      $finish;
    end
  end

  // Accept results with a random stall per item
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    recv_calm = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
      taken++;
      if (taken % 24 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Present one item; valid stays high if the next item follows at once
  task automatic send_access(input logic mode, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    clcc_req_t req;
    int        gap;
    req.mode = mode;
    req.address = addr;
    req.write_data = wdata;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp_q.size() != 0) @(posedge clk);
  endtask

  // Write the placement register while the block is idle
  task automatic set_placement(input logic [PLACE_W-1:0] code);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset placement: cold misses, store without allocation, store hit, conflict
  task automatic test_direct_mapped();
    send_access(MODE_LOAD,  11'd0,    32'h0);
    send_access(MODE_STORE, 11'd2047, 32'h7FFF_FFFF);
    send_access(MODE_LOAD,  11'd2047, 32'hFFFF_FFFF);
    send_access(MODE_LOAD,  11'd2047, 32'h0);
    send_access(MODE_STORE, 11'd2047, 32'h8000_0000);
    send_access(MODE_LOAD,  11'd2047, 32'h0);
    send_access(MODE_LOAD,  11'd2031, 32'h0);
    send_access(MODE_STORE, 11'd16,   32'hFFFF_FFFF);
  endtask

  // Lines filled under another placement are found by whole-address tag
  task automatic test_fully_associative();
    set_placement(PL_FULL);
    send_access(MODE_LOAD,  11'd0,    32'h0);
    send_access(MODE_LOAD,  11'd16,   32'h0);
    send_access(MODE_LOAD,  11'd2047, 32'h0);
    send_access(MODE_LOAD,  11'd16,   32'h0);
    send_access(MODE_STORE, 11'd1024, 32'h0);
  endtask

  // Overfill set 0 so the least recent way is replaced
  task automatic test_set_associative();
    set_placement(PL_SET);
    send_access(MODE_LOAD, 11'd4,  32'h0);
    send_access(MODE_LOAD, 11'd8,  32'h0);
    send_access(MODE_LOAD, 11'd12, 32'h0);
    send_access(MODE_LOAD, 11'd16, 32'h0);
    send_access(MODE_LOAD, 11'd20, 32'h0);
    send_access(MODE_LOAD, 11'd4,  32'h0);
  endtask

  // Unused code: every load misses and is served from memory
  task automatic test_bypass();
    set_placement(PL_BYPASS);
    send_access(MODE_LOAD,  11'd16,   32'h0);
    send_access(MODE_STORE, 11'd2047, 32'h5A5A_A5A5);
    send_access(MODE_LOAD,  11'd2047, 32'h0);
  endtask

  // Random loads and stores over a colliding working set, in six phases over the placements
  task automatic test_random_traffic();
    logic [PLACE_W-1:0] plan [6] = '{PL_FULL, PL_SET, PL_DIRECT, PL_BYPASS, PL_SET, PL_FULL};
    int                 quota [6] = '{80, 80, 80, 20, 70, 70};
    logic [ADDR_W-1:0]  pool [POOL_SIZE];
    logic [ADDR_W-1:0]  addr;
    for (int ph = 0; ph < 6; ph++) begin
      set_placement(plan[ph]);
      // Few tags and few low bits: overflows the cache and collides in lines and sets
      for (int k = 0; k < POOL_SIZE; k++) begin
        pool[k] = ADDR_W'($urandom);
        pool[k][3:0] = 4'($urandom_range(0, 5));
        pool[k][ADDR_W-1:ADDR_W-2] = 2'($urandom_range(0, 3));
        pool[k][ADDR_W-3:4] = '0;
      end
      for (int n = 0; n < quota[ph]; n++) begin
        if ($urandom_range(0, 3) == 0) addr = ADDR_W'($urandom);
        else addr = pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_access(($urandom_range(0, 9) < 3) ? MODE_STORE : MODE_LOAD, addr, $urandom);
      end
    end
    send_calm = 1'b0;
  endtask

  initial begin
    placement_mirror = PL_DIRECT;
    load_misses = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      cl_valid[i] = 1'b0;
      cl_tag[i] = '0;
      cl_word[i] = '0;
      cl_rank[i] = '0;
    end
    for (int i = 0; i < MEMORY_WORDS; i++) mem_image[i] = '0;
    mismatches = 0;
    load_count = 0;
    store_count = 0;
    hit_count = 0;
    idle_cycles = 0;
    send_calm = 1'b0;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= PL_DIRECT;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_direct_mapped();
    test_fully_associative();
    test_set_associative();
    test_bypass();
    test_random_traffic();
    set_placement(PL_DIRECT);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d stores under all four placement codes.",
             load_count, store_count);
    $display("%0d results hit the cache; %0d load misses counted.", hit_count, load_misses);
    if (mismatches == 0) begin
      $display("PASS configurable_lru_cache_controller");
    end else begin
      $display("FAIL configurable_lru_cache_controller");
    end
    $finish;
  end

endmodule
